// ===== sv/lkv_pkg.sv =====
package lkv_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int KEY_BITS_DEFAULT   = 64;
    localparam int VALUE_BITS_DEFAULT = 64;

    localparam int CAPACITY_BITS = 5;
    localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 5'd16;

    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_GET    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic load_out;
    } lkv_cmd_t;

    typedef struct packed {
        logic out_free;
    } lkv_status_t;

endpackage

// ===== sv/lkv_ctrl.sv =====
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lkv_status_t status,
    output lkv_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.lookup   = 1'b0;
        cmd.update   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/lkv_dpath.sv =====
module lkv_dpath
    import lkv_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lkv_cmd_t                 cmd,
    output lkv_status_t              status,
    input  logic                     cfg_valid,
    input  logic [CAPACITY_BITS-1:0] cfg_data,
    input  logic [1:0]               func,
    input  logic [KEY_BITS-1:0]      key,
    input  logic [VALUE_BITS-1:0]    value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [VALUE_BITS-1:0]    read_value,
    output logic                     evicted,
    output logic [KEY_BITS-1:0]      victim_key
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CAPACITY_BITS-1:0] capacity_reg;
    logic [CW-1:0]            cap_eff;

    logic [1:0]            req_func_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;

    logic [DEPTH-1:0]    slot_valid_reg;
    logic [DEPTH-1:0]    slot_valid_next;
    logic [KEY_BITS-1:0] slot_key_reg [DEPTH];
    logic [IW-1:0]       rank_reg [DEPTH];
    logic [IW-1:0]       rank_next [DEPTH];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    logic [VALUE_BITS-1:0] value_mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] lru_reg;
    logic             full_reg;

    logic                  res_hit_reg;
    logic                  res_get_reg;
    logic                  res_evicted_reg;
    logic [KEY_BITS-1:0]   res_victim_key_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [VALUE_BITS-1:0] out_read_value_reg;
    logic                  out_evicted_reg;
    logic [KEY_BITS-1:0]   out_victim_key_reg;

    logic                is_put;
    logic                is_get;
    logic                is_remove;
    logic                any_match;
    logic                do_touch;
    logic                do_drop;
    logic                do_insert;
    logic                do_evict;
    logic                have_slot;
    logic [DEPTH-1:0]    vacant;
    logic [DEPTH-1:0]    ins_oh;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       ins_idx;
    logic [IW-1:0]       hit_rank;
    logic [KEY_BITS-1:0] lru_key;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(capacity_reg) > DEPTH)
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = CW'(capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_func_reg  <= func;
            req_key_reg   <= key;
            req_value_reg <= value;
        end
    end

    // Every slot compares its key at once; the least recent slot holds rank count - 1.
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                match_reg[i] <= slot_valid_reg[i] && (slot_key_reg[i] == req_key_reg);
                lru_reg[i]   <= slot_valid_reg[i] &&
                                ((CW'(rank_reg[i]) + CW'(1)) == count_reg);
            end
            full_reg <= (count_reg >= cap_eff);
        end
    end

    assign is_put    = (req_func_reg == FUNC_PUT);
    assign is_get    = (req_func_reg == FUNC_GET);
    assign is_remove = (req_func_reg == FUNC_REMOVE);
    assign any_match = |match_reg;
    assign do_touch  = any_match && (is_put || is_get);
    assign do_drop   = any_match && is_remove;
    assign do_insert = is_put && !any_match;
    assign do_evict  = do_insert && full_reg;

    assign vacant    = ~slot_valid_reg | (do_evict ? lru_reg : '0);
    assign ins_oh    = vacant & (~vacant + DEPTH'(1));
    assign have_slot = |vacant;

    always_comb
    begin
        hit_idx  = '0;
        ins_idx  = '0;
        hit_rank = '0;
        lru_key  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (ins_oh[i])
            begin
                ins_idx = ins_idx | IW'(i);
            end
            if (lru_reg[i])
            begin
                lru_key = lru_key | slot_key_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_valid_next[i] = slot_valid_reg[i];
            rank_next[i]       = rank_reg[i];
            if (do_touch)
            begin
                if (match_reg[i])
                begin
                    rank_next[i] = '0;
                end
                else if (slot_valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            else if (do_drop)
            begin
                if (match_reg[i])
                begin
                    slot_valid_next[i] = 1'b0;
                    rank_next[i]       = '0;
                end
                else if (slot_valid_reg[i] && (rank_reg[i] > hit_rank))
                begin
                    rank_next[i] = rank_reg[i] - IW'(1);
                end
            end
            else if (do_insert)
            begin
                if (do_evict && lru_reg[i])
                begin
                    slot_valid_next[i] = 1'b0;
                    rank_next[i]       = '0;
                end
                if (have_slot)
                begin
                    if (ins_oh[i])
                    begin
                        slot_valid_next[i] = 1'b1;
                        rank_next[i]       = '0;
                    end
                    else if (slot_valid_next[i])
                    begin
                        rank_next[i] = rank_reg[i] + IW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_drop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (do_insert)
        begin
            count_next = count_reg + CW'(have_slot) - CW'(do_evict);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            count_reg      <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.update && do_insert && ins_oh[i])
            begin
                slot_key_reg[i] <= req_key_reg;
            end
        end
    end

    assign mem_we    = cmd.update && ((is_put && any_match) || (do_insert && have_slot));
    assign mem_waddr = do_insert ? ins_idx : hit_idx;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[mem_waddr] <= req_value_reg;
        end
        if (cmd.update)
        begin
            rd_data_reg <= value_mem[hit_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_hit_reg        <= any_match && (is_put || is_get || is_remove);
            res_get_reg        <= any_match && is_get;
            res_evicted_reg    <= do_evict;
            res_victim_key_reg <= do_evict ? lru_key : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hit_reg        <= res_hit_reg;
            out_read_value_reg <= res_get_reg ? rd_data_reg : '0;
            out_evicted_reg    <= res_evicted_reg;
            out_victim_key_reg <= res_victim_key_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_read_value_reg;
    assign evicted    = out_evicted_reg;
    assign victim_key = out_victim_key_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(count_reg))
        else $error("entry count differs from the number of valid slots");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the depth");

    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $onehot0(match_reg))
        else $error("key found in more than one slot");

    a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> ($onehot0(lru_reg) && ((count_reg == '0) || $onehot(lru_reg))))
        else $error("least recent slot is not unique");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_evicted_reg && out_hit_reg))
        else $error("eviction reported on a hit");
`endif

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Each accepted item is captured, then the controller steps it through a key compare,
// a state and value memory update, and an output load, which waits until the output
// register is free; no new item is taken until the output load is done.
// Reset clears all valid bits, recency ranks and the entry count at once, and sets
// capacity to 16; no clearing pass is needed, so items are taken right after reset.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               func,
    input  logic [KEY_BITS-1:0]      key,
    input  logic [VALUE_BITS-1:0]    value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [VALUE_BITS-1:0]    read_value,
    output logic                     evicted,
    output logic [KEY_BITS-1:0]      victim_key,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAPACITY_BITS-1:0] cfg_data
);

    lkv_cmd_t    cmd;
    lkv_status_t status;

    assign cfg_ready = 1'b1;

    lkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lkv_dpath #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .func       (func),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value),
        .evicted    (evicted),
        .victim_key (victim_key)
    );

endmodule
